@@ hw/rtl/piecewise_linear_setpoint_unit_assert.svh @@
// Assertion macros shared by the setpoint unit's RTL files.
`ifndef PIECEWISE_LINEAR_SETPOINT_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_SETPOINT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLS_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("setpoint unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("setpoint unit assertion failed");

`endif

@@ hw/rtl/pls_pkg.sv @@
// Types and constants shared by the piecewise linear setpoint unit.
package pls_pkg;

    localparam int PT_W      = 16;        // width of a breakpoint time or temperature
    localparam int ENTRY_W   = 2 * PT_W;  // one table entry: time above, temperature below
    localparam int CNT_W     = 5;         // width of the point count register
    localparam int IDX_IN_W  = 4;         // width of the point_index field
    localparam int MIN_W     = 11;        // whole minutes of a 16-bit seconds value

    // Division by 60 as a multiplication by 2^21 / 60, rounded up, then a shift right by MIN_SHIFT.
    localparam logic [PT_W-1:0] MIN_RECIP = 16'd34953;
    localparam int              MIN_SHIFT = 21;

    // Restoring division: one quotient bit per step.
    localparam int DIV_STEPS = PT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MINUTE,
        ST_CHECK,
        ST_SCAN,
        ST_MULT,
        ST_DIVIDE,
        ST_FINAL
    } state_t;

    typedef enum logic [2:0] {
        RES_END,
        RES_HEAD,
        RES_LAST,
        RES_PREV,
        RES_INTERP
    } res_sel_t;

    typedef struct packed {
        logic     load_query;
        logic     write_point;
        logic     calc_minute;
        logic     scan_begin;
        logic     scan_next;
        logic     seg_load;
        logic     mult_load;
        logic     div_step;
        logic     result;
        res_sel_t res_sel;
    } pls_cmd_t;

    typedef struct packed {
        logic out_range;
        logic eq_first;
        logic eq_last;
        logic seg_hit;
        logic node_hit;
        logic flat;
        logic scan_end;
        logic div_last;
    } pls_status_t;

endpackage

@@ hw/rtl/piecewise_linear_setpoint_unit.sv @@
// Top level of the piecewise linear (ramp and soak) setpoint unit.
//
//  Channel   Signals                                       Transaction completes
//  --------  --------------------------------------------  -------------------------------
//  command   start, busy, func, point_index,               rising edge with start high and
//            point_minutes, point_degrees, elapsed_seconds busy low
//  result    result_valid, setpoint, out_of_profile        every edge that ends a cycle
//                                                          with result_valid high
//  config    cfg_valid, cfg_ready, cfg_data                rising edge with cfg_valid and
//                                                          cfg_ready both high
//
// A write transaction stores its breakpoint in the accepting cycle and leaves busy low.
// A query holds busy high while the controller walks the table, one entry per cycle through
// the single read port: the result comes from the check against the first and last entries at
// the earliest, and from the scan and the 16-step divider when it has to interpolate, the walk
// covering the point count clamped to the range 2 to MAX_POINTS.
// Reset clears the controller and sets point_count to 2; the breakpoint table is not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`include "piecewise_linear_setpoint_unit_assert.svh"

module piecewise_linear_setpoint_unit
    import pls_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [IDX_IN_W-1:0] point_index,
    input  logic [PT_W-1:0]     point_minutes,
    input  logic [PT_W-1:0]     point_degrees,
    input  logic [PT_W-1:0]     elapsed_seconds,

    output logic                result_valid,
    output logic [PT_W-1:0]     setpoint,
    output logic                out_of_profile,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data
);

    pls_cmd_t    cmd;
    pls_status_t status;

    // The count register can be written at any time; the user keeps to idle periods.
    assign cfg_ready = 1'b1;

    // The controller only sequences; all table accesses and arithmetic sit in the datapath.
    pls_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    pls_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .point_index     (point_index),
        .point_minutes   (point_minutes),
        .point_degrees   (point_degrees),
        .elapsed_seconds (elapsed_seconds),
        .result_valid    (result_valid),
        .setpoint        (setpoint),
        .out_of_profile  (out_of_profile)
    );

    // A result only ever closes a query, so the unit was busy in the cycle before it.
    `PLS_ASSERT_IMPL(a_result_after_busy, clk, rst_n, result_valid, $past(busy))
    // Two queries cannot finish in adjacent cycles.
    `PLS_ASSERT_NEXT(a_result_single_cycle, clk, rst_n, result_valid, !result_valid)
    // An answer outside the profile carries a zero setpoint.
    `PLS_ASSERT_IMPL(a_end_zero_setpoint, clk, rst_n, result_valid && out_of_profile, setpoint == '0)
    // A breakpoint write completes in the cycle that accepts it.
    `PLS_ASSERT_NEXT(a_write_stays_idle, clk, rst_n, start && !busy && (func == FUNC_WRITE), !busy)

endmodule

@@ hw/rtl/pls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/pls_ctrl.sv @@
// Controller state machine of the setpoint unit.
module pls_ctrl
    import pls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        func,
    input  pls_status_t status,
    output logic        busy,
    output pls_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_END;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_MINUTE;
                    end
                    else
                    begin
                        cmd.write_point = 1'b1;
                    end
                end
            end
            ST_MINUTE:
            begin
                cmd.calc_minute = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (status.out_range)
                begin
                    cmd.result  = 1'b1;
                    cmd.res_sel = RES_END;
                    state_next  = ST_IDLE;
                end
                else if (status.eq_first)
                begin
                    cmd.result  = 1'b1;
                    cmd.res_sel = RES_HEAD;
                    state_next  = ST_IDLE;
                end
                else if (status.eq_last)
                begin
                    cmd.result  = 1'b1;
                    cmd.res_sel = RES_LAST;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.scan_begin = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (status.seg_hit && (status.node_hit || status.flat))
                begin
                    cmd.result  = 1'b1;
                    cmd.res_sel = RES_PREV;
                    state_next  = ST_IDLE;
                end
                else if (status.seg_hit)
                begin
                    cmd.seg_load = 1'b1;
                    state_next   = ST_MULT;
                end
                else if (status.scan_end)
                begin
                    // Times that do not increase can leave the minute in no segment.
                    cmd.result  = 1'b1;
                    cmd.res_sel = RES_END;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_MULT:
            begin
                cmd.mult_load = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.result  = 1'b1;
                cmd.res_sel = RES_INTERP;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/pls_datapath.sv @@
// Datapath of the setpoint unit: profile table, segment search and interpolation.
`include "piecewise_linear_setpoint_unit_assert.svh"

module pls_datapath
    import pls_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pls_cmd_t            cmd,
    output pls_status_t         status,
    input  logic                cfg_valid,
    input  logic [CNT_W-1:0]    cfg_data,
    input  logic [IDX_IN_W-1:0] point_index,
    input  logic [PT_W-1:0]     point_minutes,
    input  logic [PT_W-1:0]     point_degrees,
    input  logic [PT_W-1:0]     elapsed_seconds,
    output logic                result_valid,
    output logic [PT_W-1:0]     setpoint,
    output logic                out_of_profile
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [CNT_W-1:0]     point_count_reg;
    logic [IDX_W-1:0]     last_idx;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [PT_W-1:0]      rd_time;
    logic [PT_W-1:0]      rd_deg;

    logic [PT_W-1:0]      secs_reg;
    logic [MIN_W-1:0]     minute_reg;
    logic [PT_W-1:0]      minute_ext;
    logic [2*PT_W-1:0]    min_prod;
    logic [PT_W-1:0]      last_time_reg;
    logic [PT_W-1:0]      last_deg_reg;
    logic [PT_W-1:0]      prev_time_reg;
    logic [PT_W-1:0]      prev_deg_reg;
    logic [IDX_W-1:0]     cur_idx_reg;

    logic [PT_W-1:0]      d0_reg;
    logic                 rise_reg;
    logic [PT_W-1:0]      dd_reg;
    logic [PT_W-1:0]      dmin_reg;
    logic [PT_W-1:0]      dtime_reg;
    logic [2*PT_W-1:0]    seg_prod;
    logic [PT_W-1:0]      rem_reg;
    logic [PT_W-1:0]      quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PT_W:0]        trial;
    logic                 trial_ge;

    logic                 result_valid_reg;
    logic [PT_W-1:0]      setpoint_reg;
    logic                 eop_reg;
    logic [PT_W-1:0]      setpoint_next;
    logic                 eop_next;
    logic [PT_W-1:0]      interp;

    // Point count, clamped to the range the table supports.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            point_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (point_count_reg < CNT_W'(2))
        begin
            last_idx = IDX_W'(1);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = IDX_W'(32'(point_count_reg) - 32'd1);
        end
    end

    // Table port control. Writes outside the table are dropped.
    assign ram_we    = cmd.write_point && (32'(point_index) < MAX_POINTS);
    assign ram_waddr = IDX_W'(point_index);
    assign ram_re    = cmd.load_query || cmd.calc_minute || cmd.scan_begin || cmd.scan_next;

    always_comb
    begin
        priority if (cmd.load_query)
        begin
            ram_raddr = last_idx;
        end
        else if (cmd.calc_minute)
        begin
            ram_raddr = '0;
        end
        else if (cmd.scan_begin)
        begin
            ram_raddr = IDX_W'(1);
        end
        else
        begin
            ram_raddr = IDX_W'(cur_idx_reg + 1'b1);
        end
    end

    pls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({point_minutes, point_degrees}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_time = ram_rdata[ENTRY_W-1:PT_W];
    assign rd_deg  = ram_rdata[PT_W-1:0];

    assign min_prod   = 32'(secs_reg) * 32'(MIN_RECIP);
    assign minute_ext = PT_W'(minute_reg);
    assign seg_prod   = 32'(dd_reg) * 32'(dmin_reg);

    // One step of restoring division: the remainder stays below the divisor.
    assign trial    = {rem_reg, quo_reg[PT_W-1]};
    assign trial_ge = (trial >= {1'b0, dtime_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            secs_reg <= elapsed_seconds;
        end
        if (cmd.calc_minute)
        begin
            minute_reg    <= min_prod[MIN_SHIFT +: MIN_W];
            last_time_reg <= rd_time;
            last_deg_reg  <= rd_deg;
        end
        if (cmd.scan_begin || cmd.scan_next)
        begin
            prev_time_reg <= rd_time;
            prev_deg_reg  <= rd_deg;
        end
        if (cmd.scan_begin)
        begin
            cur_idx_reg <= IDX_W'(1);
        end
        else if (cmd.scan_next)
        begin
            cur_idx_reg <= IDX_W'(cur_idx_reg + 1'b1);
        end
        if (cmd.seg_load)
        begin
            d0_reg    <= prev_deg_reg;
            rise_reg  <= (rd_deg > prev_deg_reg);
            dd_reg    <= (rd_deg > prev_deg_reg) ? (rd_deg - prev_deg_reg)
                                                 : (prev_deg_reg - rd_deg);
            dmin_reg  <= minute_ext - prev_time_reg;
            dtime_reg <= rd_time - prev_time_reg;
        end
        if (cmd.mult_load)
        begin
            rem_reg <= seg_prod[2*PT_W-1:PT_W];
            quo_reg <= seg_prod[PT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? PT_W'(trial - {1'b0, dtime_reg}) : trial[PT_W-1:0];
            quo_reg <= {quo_reg[PT_W-2:0], trial_ge};
        end
        if (cmd.result)
        begin
            setpoint_reg <= setpoint_next;
            eop_reg      <= eop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mult_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= DIV_CNT_W'(div_cnt_reg + 1'b1);
            end
            result_valid_reg <= cmd.result;
        end
    end

    assign interp = rise_reg ? PT_W'(d0_reg + quo_reg) : PT_W'(d0_reg - quo_reg);

    always_comb
    begin
        setpoint_next = '0;
        eop_next      = 1'b0;
        unique case (cmd.res_sel)
            RES_END:
            begin
                eop_next = 1'b1;
            end
            RES_HEAD:   setpoint_next = rd_deg;
            RES_LAST:   setpoint_next = last_deg_reg;
            RES_PREV:   setpoint_next = prev_deg_reg;
            RES_INTERP: setpoint_next = interp;
            default:
            begin
                eop_next = 1'b1;
            end
        endcase
    end

    assign status.out_range = (minute_ext > last_time_reg) || (minute_ext < rd_time);
    assign status.eq_first  = (minute_ext == rd_time);
    assign status.eq_last   = (minute_ext == last_time_reg);
    assign status.seg_hit   = (prev_time_reg <= minute_ext) && (minute_ext < rd_time);
    assign status.node_hit  = (minute_ext == prev_time_reg);
    assign status.flat      = (prev_deg_reg == rd_deg);
    assign status.scan_end  = (cur_idx_reg == last_idx);
    assign status.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign result_valid   = result_valid_reg;
    assign setpoint       = setpoint_reg;
    assign out_of_profile = eop_reg;

    `PLS_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, cmd.div_step, rem_reg < dtime_reg)

endmodule
